/* rtl/euxr_pkg.sv */
// euxr_pkg: shared types, constants and tables for the euler xyz vector rotator
// used by euxr_trig, euler_xyz_vector_rotator_core and euxr_checker
package euxr_pkg;

  localparam int TRIG_FRAC_BITS = 16;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int ANGLE_W        = 16;
  localparam int VEC_W          = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int NUM_AXES       = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 2'd2;

  // opcodes
  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    T_IDLE,
    T_REDUCE,
    T_PLO,
    T_PHI,
    T_TH,
    T_SQ,
    T_MUL,
    T_DIV,
    T_QUO,
    T_SFIN,
    T_CFIN
  } trig_state_e;

  typedef logic signed [TRIG_W-1:0] trig_val_t;

  typedef struct packed {
    trig_val_t [NUM_AXES-1:0] sin_v;
    trig_val_t [NUM_AXES-1:0] cos_v;
    logic                     busy;
  } trig_st_t;

  typedef struct packed {
    logic                    opcode;
    logic signed [VEC_W-1:0] in_x;
    logic signed [VEC_W-1:0] in_y;
    logic signed [VEC_W-1:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    saturated;
  } out_word_t;

  // angle reduction and radian conversion
  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam logic [63:0] PI_Q44 = 64'h3243_F6A8_885A;  // pi * 2^44
  // 11520 * 2^14 = 45 * 2^22: scales r * pi * 2^44 down to q30 radians
  localparam logic [63:0] TH_DEN = 64'd188743680;
  // pi * 2^44 split into whole multiples of the scale and a remainder
  localparam logic [18:0] TH_A = 19'(PI_Q44 / TH_DEN);
  localparam logic [27:0] TH_B = 28'(PI_Q44 % TH_DEN);
  // ceil(2^24 / 45), exact for dividends below 2^18
  localparam logic [18:0] RECIP_45 = 19'(((64'd1 << 24) + 64'd44) / 64'd45);
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // n / d as ((n >> pre) * mul) >> post, d = 2^pre * odd,
  // mul = ceil(2^post / odd), exact for n below 2^32
  typedef struct packed {
    logic [1:0]  pre;
    logic [5:0]  post;
    logic [31:0] mul;
  } recip_t;

  // taylor series divisors, sine
  function automatic recip_t sin_recip(input logic [2:0] i);
    recip_t d;
    unique case (i)
      3'd0:    d = '{pre: 2'd2, post: 6'd37, mul: 32'(((64'd1 << 37) + 64'd38) / 64'd39)};
      3'd1:    d = '{pre: 2'd1, post: 6'd37, mul: 32'(((64'd1 << 37) + 64'd54) / 64'd55)};
      3'd2:    d = '{pre: 2'd3, post: 6'd35, mul: 32'(((64'd1 << 35) + 64'd8) / 64'd9)};
      3'd3:    d = '{pre: 2'd1, post: 6'd36, mul: 32'(((64'd1 << 36) + 64'd20) / 64'd21)};
      3'd4:    d = '{pre: 2'd2, post: 6'd34, mul: 32'(((64'd1 << 34) + 64'd4) / 64'd5)};
      3'd5:    d = '{pre: 2'd1, post: 6'd33, mul: 32'(((64'd1 << 33) + 64'd2) / 64'd3)};
      default: d = '{pre: 2'd0, post: 6'd0, mul: 32'd1};
    endcase
    return d;
  endfunction

  // taylor series divisors, cosine
  function automatic recip_t cos_recip(input logic [2:0] i);
    recip_t d;
    unique case (i)
      3'd0:    d = '{pre: 2'd1, post: 6'd38, mul: 32'(((64'd1 << 38) + 64'd90) / 64'd91)};
      3'd1:    d = '{pre: 2'd2, post: 6'd37, mul: 32'(((64'd1 << 37) + 64'd32) / 64'd33)};
      3'd2:    d = '{pre: 2'd1, post: 6'd37, mul: 32'(((64'd1 << 37) + 64'd44) / 64'd45)};
      3'd3:    d = '{pre: 2'd3, post: 6'd34, mul: 32'(((64'd1 << 34) + 64'd6) / 64'd7)};
      3'd4:    d = '{pre: 2'd1, post: 6'd35, mul: 32'(((64'd1 << 35) + 64'd14) / 64'd15)};
      3'd5:    d = '{pre: 2'd2, post: 6'd33, mul: 32'(((64'd1 << 33) + 64'd2) / 64'd3)};
      3'd6:    d = '{pre: 2'd1, post: 6'd31, mul: 32'h8000_0000};
      default: d = '{pre: 2'd0, post: 6'd0, mul: 32'd1};
    endcase
    return d;
  endfunction

endpackage

/* rtl/euxr_trig.sv */
// euxr_trig: angle registers and sequential sine/cosine unit
// constant divisions done by reciprocal multiplies, registered products; uses euxr_pkg
module euxr_trig import euxr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ANGLE_W-1:0]   cfg_wdata_i,
  output trig_st_t             trig_o
);

  trig_state_e state_q, state_d;
  logic signed [ANGLE_W-1:0] ang_q [NUM_AXES];
  logic signed [ANGLE_W-1:0] ang_d [NUM_AXES];
  trig_val_t sin_q [NUM_AXES];
  trig_val_t sin_d [NUM_AXES];
  trig_val_t cos_q [NUM_AXES];
  trig_val_t cos_d [NUM_AXES];
  logic [NUM_AXES-1:0] pend_q, pend_d, pend_clr;
  logic [1:0] axis_q, axis_d;
  logic [2:0] iter_q, iter_d;
  logic       cos_ph_q, cos_ph_d;

  logic [14:0] red_q, red_d;
  logic [1:0]  quad_q, quad_d;
  logic [12:0] r_q, r_d;
  logic [31:0] ra_q, ra_d;
  logic [40:0] rb_q, rb_d;
  logic [36:0] qp_q, qp_d;
  logic [30:0] th_q, th_d;
  logic [31:0] x2_q, x2_d;
  logic [30:0] t_q, t_d;
  logic [30:0] s_q, s_d;
  logic [31:0] nq_q, nq_d;
  logic [62:0] dp_q, dp_d;

  logic [31:0]    ra;
  logic [40:0]    rb;
  logic [36:0]    qp;
  logic [61:0]    sq;
  logic [62:0]    mp;
  logic [61:0]    sp;
  recip_t         rc;
  logic [30:0]    nsh;
  logic [62:0]    dprod;
  logic [62:0]    quo_full;
  logic [31:0]    sub;
  logic [31:0]    sr_sum, cr_sum;
  trig_val_t      sr, cr;
  logic signed [ANGLE_W:0] ang_red;
  logic [1:0]     sel;

  // theta = r * TH_A + floor(floor(r * TH_B / 2^22) / 45)
  assign ra = 32'(r_q) * 32'(TH_A);
  assign rb = 41'(r_q) * 41'(TH_B);
  assign qp = 37'(rb_q[40:22]) * 37'(RECIP_45);

  assign sq  = 62'(th_q) * 62'(th_q);
  assign mp  = 63'(x2_q) * 63'(t_q);
  assign sp  = 62'(th_q) * 62'(t_q);

  // series term divided by its constant
  assign rc       = cos_ph_q ? cos_recip(iter_q) : sin_recip(iter_q);
  assign nsh      = 31'(nq_q >> rc.pre);
  assign dprod    = 63'(nsh) * 63'(rc.mul);
  assign quo_full = dp_q >> rc.post;
  assign sub      = quo_full[31:0];

  // round q30 to the trig fraction width
  assign sr_sum = 32'(s_q) + 32'(1 << (29 - TRIG_FRAC_BITS));
  assign cr_sum = 32'(t_q) + 32'(1 << (29 - TRIG_FRAC_BITS));
  assign sr     = TRIG_W'(sr_sum >> (30 - TRIG_FRAC_BITS));
  assign cr     = TRIG_W'(cr_sum >> (30 - TRIG_FRAC_BITS));

  always_comb begin
    priority if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  // reduce into 0..FULL_TURN-1
  always_comb begin
    ang_red = (ANGLE_W+1)'(ang_q[sel]);
    if (ang_red < 0) begin
      ang_red = ang_red + (ANGLE_W+1)'(FULL_TURN);
    end
    if (ang_red < 0) begin
      ang_red = ang_red + (ANGLE_W+1)'(FULL_TURN);
    end
    if (ang_red >= (ANGLE_W+1)'(FULL_TURN)) begin
      ang_red = ang_red - (ANGLE_W+1)'(FULL_TURN);
    end
  end

  always_comb begin
    state_d  = state_q;
    ang_d    = ang_q;
    sin_d    = sin_q;
    cos_d    = cos_q;
    pend_clr = '0;
    axis_d   = axis_q;
    iter_d   = iter_q;
    cos_ph_d = cos_ph_q;
    red_d    = red_q;
    quad_d   = quad_q;
    r_d      = r_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    qp_d     = qp_q;
    th_d     = th_q;
    x2_d     = x2_q;
    t_d      = t_q;
    s_d      = s_q;
    nq_d     = nq_q;
    dp_d     = dp_q;

    unique case (state_q)
      T_IDLE: begin
        if (|pend_q) begin
          pend_clr[sel] = 1'b1;
          axis_d        = sel;
          red_d         = ang_red[14:0];
          state_d       = T_REDUCE;
        end
      end
      T_REDUCE: begin
        priority if (red_q >= 15'(3 * QUARTER_TURN)) begin
          quad_d = 2'd3;
          r_d    = 13'(red_q - 15'(3 * QUARTER_TURN));
        end else if (red_q >= 15'(2 * QUARTER_TURN)) begin
          quad_d = 2'd2;
          r_d    = 13'(red_q - 15'(2 * QUARTER_TURN));
        end else if (red_q >= 15'(QUARTER_TURN)) begin
          quad_d = 2'd1;
          r_d    = 13'(red_q - 15'(QUARTER_TURN));
        end else begin
          quad_d = 2'd0;
          r_d    = red_q[12:0];
        end
        state_d = T_PLO;
      end
      T_PLO: begin
        ra_d    = ra;
        rb_d    = rb;
        state_d = T_PHI;
      end
      T_PHI: begin
        qp_d    = qp;
        state_d = T_TH;
      end
      T_TH: begin
        th_d    = 31'(ra_q + 32'(qp_q[36:24]));
        state_d = T_SQ;
      end
      T_SQ: begin
        x2_d     = sq[61:30];
        t_d      = Q30_ONE;
        iter_d   = '0;
        cos_ph_d = 1'b0;
        state_d  = T_MUL;
      end
      T_MUL: begin
        nq_d    = mp[61:30];
        state_d = T_DIV;
      end
      T_DIV: begin
        dp_d    = dprod;
        state_d = T_QUO;
      end
      T_QUO: begin
        t_d    = (sub > 32'(Q30_ONE)) ? '0 : Q30_ONE - sub[30:0];
        iter_d = iter_q + 3'd1;
        if (!cos_ph_q && iter_q == 3'd5) begin
          state_d = T_SFIN;
        end else if (cos_ph_q && iter_q == 3'd6) begin
          state_d = T_CFIN;
        end else begin
          state_d = T_MUL;
        end
      end
      T_SFIN: begin
        s_d      = sp[60:30];
        t_d      = Q30_ONE;
        iter_d   = '0;
        cos_ph_d = 1'b1;
        state_d  = T_MUL;
      end
      T_CFIN: begin
        // quadrant fold
        unique case (quad_q)
          2'd0: begin
            sin_d[axis_q] = sr;
            cos_d[axis_q] = cr;
          end
          2'd1: begin
            sin_d[axis_q] = cr;
            cos_d[axis_q] = -sr;
          end
          2'd2: begin
            sin_d[axis_q] = -sr;
            cos_d[axis_q] = -cr;
          end
          default: begin
            sin_d[axis_q] = -cr;
            cos_d[axis_q] = sr;
          end
        endcase
        state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase

    pend_d = pend_q & ~pend_clr;
    if (cfg_we_i && (cfg_idx_i == REG_ANGLE_X || cfg_idx_i == REG_ANGLE_Y ||
                     cfg_idx_i == REG_ANGLE_Z)) begin
      pend_d[cfg_idx_i] = 1'b1;
      ang_d[cfg_idx_i]  = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      pend_q   <= '0;
      axis_q   <= '0;
      iter_q   <= '0;
      cos_ph_q <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        ang_q[i] <= '0;
        sin_q[i] <= '0;
        cos_q[i] <= TRIG_W'(1 << TRIG_FRAC_BITS);
      end
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      axis_q   <= axis_d;
      iter_q   <= iter_d;
      cos_ph_q <= cos_ph_d;
      ang_q    <= ang_d;
      sin_q    <= sin_d;
      cos_q    <= cos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q  <= red_d;
    quad_q <= quad_d;
    r_q    <= r_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    qp_q   <= qp_d;
    th_q   <= th_d;
    x2_q   <= x2_d;
    t_q    <= t_d;
    s_q    <= s_d;
    nq_q   <= nq_d;
    dp_q   <= dp_d;
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      trig_o.sin_v[i] = sin_q[i];
      trig_o.cos_v[i] = cos_q[i];
    end
    trig_o.busy = (state_q != T_IDLE) || (|pend_q);
  end

endmodule

/* rtl/euler_xyz_vector_rotator_core.sv */
// euler_xyz_vector_rotator_core: top level, six-stage rotation pipeline
// depends on euxr_pkg and euxr_trig
//
// Rotates a Q15.16 vector by three Euler angles (1/64 degree units) held in
// registers 0..2. Opcode forward rotates about X, then Y, then Z; opcode inverse
// rotates about Z, then Y, then X by the negated angles and undoes the forward
// rotation. Every rotation rounds to nearest and saturates to 32 bits; the
// saturated flag reports any clip. The pipeline has a multiply stage and an
// add/round/saturate stage per axis and takes one word per clock while the
// output is not stalled and the sine/cosine unit is idle; each stage holds
// its word under backpressure, so the input stays ready while a finished
// word waits at the output until all six stages hold a word. A register
// write starts the sine/cosine unit, which evaluates the series with
// reciprocal multiplies in place of the constant divisions; in_ready_o stays
// low while it works. Reset values give the identity rotation.
module euler_xyz_vector_rotator_core import euxr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ANGLE_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o
);

  localparam int PROD_W = TRIG_W + VEC_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int NROT   = 3;

  typedef struct packed {
    logic                    op;
    logic                    sat;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t                     v;
    axis_e                    ax;
    logic signed [PROD_W-1:0] ca;
    logic signed [PROD_W-1:0] sb;
    logic signed [PROD_W-1:0] sa;
    logic signed [PROD_W-1:0] cb;
  } mul_t;

  trig_st_t trig;

  euxr_trig u_trig (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .trig_o      (trig)
  );

  // round by the trig fraction, then clip to 32 bits; msb is the clip flag
  function automatic logic [VEC_W:0] rnd_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] u;
    logic signed [SUM_W-1:0] sh;
    logic [VEC_W:0]          r;
    u  = v + SUM_W'(1 << (TRIG_FRAC_BITS - 1));
    sh = u >>> TRIG_FRAC_BITS;
    if (sh[SUM_W-1:VEC_W-1] == '0 || sh[SUM_W-1:VEC_W-1] == '1) begin
      r = {1'b0, sh[VEC_W-1:0]};
    end else if (sh[SUM_W-1]) begin
      r = {1'b1, 1'b1, {(VEC_W-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(VEC_W-1){1'b1}}};
    end
    return r;
  endfunction

  mul_t ms_q [NROT];
  mul_t ms_d [NROT];
  vec_t vs_q [NROT];
  vec_t vs_d [NROT];
  logic [NROT-1:0] mv_q, vv_q, mv_d, vv_d;
  logic [NROT-1:0] adv_m, adv_v;
  vec_t src [NROT];
  logic [NROT-1:0] src_v;

  // stall chain from the output back
  always_comb begin
    adv_v[NROT-1] = !vv_q[NROT-1] || out_ready_i;
    for (int r = NROT - 1; r >= 0; r--) begin
      if (r < NROT - 1) begin
        adv_v[r] = !vv_q[r] || adv_m[r+1];
      end
      adv_m[r] = !mv_q[r] || adv_v[r];
    end
  end

  assign in_ready_o = adv_m[0] && !trig.busy;

  always_comb begin
    src[0].op  = in_word_i.opcode;
    src[0].sat = 1'b0;
    src[0].x   = in_word_i.in_x;
    src[0].y   = in_word_i.in_y;
    src[0].z   = in_word_i.in_z;
    src_v[0]   = in_valid_i && in_ready_o;
    for (int r = 1; r < NROT; r++) begin
      src[r]   = vs_q[r-1];
      src_v[r] = vv_q[r-1];
    end
  end

  // multiply stages: pick the axis and the pair it turns
  always_comb begin
    axis_e                   ax;
    trig_val_t               c, s;
    logic signed [VEC_W-1:0] a, b;
    for (int r = 0; r < NROT; r++) begin
      if (r == 0) begin
        ax = (src[r].op == OP_INVERSE) ? AXIS_Z : AXIS_X;
      end else if (r == 1) begin
        ax = AXIS_Y;
      end else begin
        ax = (src[r].op == OP_INVERSE) ? AXIS_X : AXIS_Z;
      end
      unique case (ax)
        AXIS_X: begin
          c = trig.cos_v[0];
          s = trig.sin_v[0];
          a = src[r].y;
          b = src[r].z;
        end
        AXIS_Y: begin
          c = trig.cos_v[1];
          s = trig.sin_v[1];
          a = src[r].z;
          b = src[r].x;
        end
        default: begin
          c = trig.cos_v[2];
          s = trig.sin_v[2];
          a = src[r].x;
          b = src[r].y;
        end
      endcase
      if (src[r].op == OP_INVERSE) begin
        s = -s;
      end
      ms_d[r].v  = src[r];
      ms_d[r].ax = ax;
      ms_d[r].ca = PROD_W'(c) * PROD_W'(a);
      ms_d[r].sb = PROD_W'(s) * PROD_W'(b);
      ms_d[r].sa = PROD_W'(s) * PROD_W'(a);
      ms_d[r].cb = PROD_W'(c) * PROD_W'(b);
      mv_d[r]    = adv_m[r] ? src_v[r] : mv_q[r];
    end
  end

  // add, round and clip stages
  always_comb begin
    logic [VEC_W:0] na, nb;
    for (int r = 0; r < NROT; r++) begin
      na = rnd_sat(SUM_W'(ms_q[r].ca) - SUM_W'(ms_q[r].sb));
      nb = rnd_sat(SUM_W'(ms_q[r].sa) + SUM_W'(ms_q[r].cb));
      vs_d[r]     = ms_q[r].v;
      vs_d[r].sat = ms_q[r].v.sat | na[VEC_W] | nb[VEC_W];
      unique case (ms_q[r].ax)
        AXIS_X: begin
          vs_d[r].y = na[VEC_W-1:0];
          vs_d[r].z = nb[VEC_W-1:0];
        end
        AXIS_Y: begin
          vs_d[r].z = na[VEC_W-1:0];
          vs_d[r].x = nb[VEC_W-1:0];
        end
        default: begin
          vs_d[r].x = na[VEC_W-1:0];
          vs_d[r].y = nb[VEC_W-1:0];
        end
      endcase
      vv_d[r] = adv_v[r] ? mv_q[r] : vv_q[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= '0;
      vv_q <= '0;
    end else begin
      mv_q <= mv_d;
      vv_q <= vv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NROT; r++) begin
      if (adv_m[r]) begin
        ms_q[r] <= ms_d[r];
      end
      if (adv_v[r]) begin
        vs_q[r] <= vs_d[r];
      end
    end
  end

  assign out_valid_o          = vv_q[NROT-1];
  assign out_word_o.out_x     = vs_q[NROT-1].x;
  assign out_word_o.out_y     = vs_q[NROT-1].y;
  assign out_word_o.out_z     = vs_q[NROT-1].z;
  assign out_word_o.saturated = vs_q[NROT-1].sat;

endmodule

/* rtl/euxr_checker.sv */
// euxr_checker: port-level assertions for the rotator core, bound to the top
// depends on euxr_pkg
module euxr_checker import euxr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input out_word_t            out_word_o
);

  logic cfg_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_seen_q <= 1'b0;
    end else if (cfg_we_i) begin
      cfg_seen_q <= 1'b1;
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word dropped or changed while stalled");

  // an angle write holds off input while sine and cosine are recomputed
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_ANGLE_X || cfg_idx_i == REG_ANGLE_Y ||
                 cfg_idx_i == REG_ANGLE_Z) |=> !in_ready_o)
    else $error("input ready during trig recompute");

  // reset angles give the identity rotation, which never clips
  a_ident_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cfg_seen_q |-> !out_word_o.saturated)
    else $error("saturation under identity rotation");

endmodule

bind euler_xyz_vector_rotator_core euxr_checker u_euxr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
